>>> rtl/ukt_pkg.sv
package ukt_pkg;

  // table size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // payload widths fixed by the interface
  localparam int ACT_W = 3;
  localparam int KEY_W = 32;
  localparam int ST_W  = 2;
  localparam int EC_W  = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_MIN    = 3'd3,
    ACT_MAX    = 3'd4,
    ACT_PRED   = 3'd5,
    ACT_SUCC   = 3'd6
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } ukt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;
  } ukt_sts_t;

  // entry count to the 5-bit result field, masked
  function automatic logic [EC_W-1:0] count_to_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+EC_W-1:0] wide;
    wide = {{EC_W{1'b0}}, c};
    return wide[EC_W-1:0];
  endfunction

endpackage

>>> rtl/ukt_in_if.sv
interface ukt_in_if
  import ukt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

>>> rtl/ukt_out_if.sv
interface ukt_out_if
  import ukt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] result_key;
  logic [ST_W-1:0]         status;
  logic [EC_W-1:0]         entry_count;

  modport source (output valid, output result_key, output status, output entry_count,
                  input ready);
  modport sink (input valid, input result_key, input status, input entry_count,
                output ready);
endinterface

>>> rtl/ukt_ctrl.sv
module ukt_ctrl
  import ukt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ukt_sts_t sts,
  output ukt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // command decode
  always_comb begin
    cmd.start  = (state_r == S_IDLE) && in_valid;
    cmd.issue  = (state_r == S_SCAN);
    cmd.commit = (state_r == S_FINISH) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.idx_last) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ukt_datapath.sv
module ukt_datapath
  import ukt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ukt_cmd_t                cmd,
  output ukt_sts_t                sts,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [KEY_W-1:0] in_key,
  output logic signed [KEY_W-1:0] out_result_key,
  output logic [ST_W-1:0]         out_status,
  output logic [EC_W-1:0]         out_entry_count
);

  // key memory, one read port, one write port
  logic signed [KEY_W-1:0] key_mem [CAPACITY];

  logic [CAPACITY-1:0]     valid_r;
  logic [CNT_W-1:0]        count_r;

  action_t                 act_r;
  logic signed [KEY_W-1:0] key_r;
  logic [IDX_W-1:0]        idx_r;

  // read stage
  logic                    rd_vld_r;
  logic                    rd_slot_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic signed [KEY_W-1:0] rd_data_r;

  // scan accumulators
  logic                    have_r;
  logic signed [KEY_W-1:0] best_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;

  logic                    eq_key, lt_key, lt_best, eq_best, take;

  logic signed [KEY_W-1:0] res_nxt;
  status_t                 st_nxt;
  logic [CNT_W-1:0]        count_nxt;
  logic                    do_ins, do_del;

  logic signed [KEY_W-1:0] out_key_r;
  status_t                 out_st_r;
  logic [EC_W-1:0]         out_ec_r;

  assign sts.idx_last = (idx_r == IDX_W'(CAPACITY - 1));

  // request capture and slot counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r <= action_t'(in_action);
      key_r <= in_key;
    end
    if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // memory read and write
  always_ff @(posedge clk) begin
    rd_data_r <= key_mem[idx_r];
    if (do_ins) begin
      key_mem[free_idx_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
    rd_slot_r <= valid_r[idx_r];
    rd_idx_r  <= idx_r;
  end

  // compare the slot under scan
  always_comb begin
    eq_key  = (rd_data_r == key_r);
    lt_key  = (rd_data_r < key_r);
    eq_best = (rd_data_r == best_r);
    lt_best = (rd_data_r < best_r);
    case (act_r)
      ACT_MIN:  take = !have_r || lt_best;
      ACT_MAX:  take = !have_r || (!lt_best && !eq_best);
      ACT_PRED: take = lt_key && (!have_r || (!lt_best && !eq_best));
      ACT_SUCC: take = !lt_key && !eq_key && (!have_r || lt_best);
      default:  take = 1'b0;
    endcase
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      have_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_slot_r && take) begin
        have_r <= 1'b1;
        best_r <= rd_data_r;
      end
      if (rd_slot_r && eq_key && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (!rd_slot_r && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // result and table update
  always_comb begin
    res_nxt   = '0;
    st_nxt    = ST_NOTFOUND;
    count_nxt = count_r;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    case (act_r)
      ACT_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else if (free_r) begin
          do_ins    = cmd.commit;
          count_nxt = count_r + CNT_W'(1);
          res_nxt   = key_r;
          st_nxt    = ST_OK;
        end
      end
      ACT_DELETE: begin
        if (hit_r) begin
          do_del    = cmd.commit;
          count_nxt = count_r - CNT_W'(1);
          res_nxt   = key_r;
          st_nxt    = ST_OK;
        end
      end
      ACT_SEARCH: begin
        if (hit_r) begin
          res_nxt = key_r;
          st_nxt  = ST_OK;
        end
      end
      ACT_MIN, ACT_MAX, ACT_PRED, ACT_SUCC: begin
        if (have_r) begin
          res_nxt = best_r;
          st_nxt  = ST_OK;
        end
      end
      default: begin
        st_nxt = ST_NOTFOUND;
      end
    endcase
  end

  // valid bits and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      if (do_ins) valid_r[free_idx_r] <= 1'b1;
      if (do_del) valid_r[hit_idx_r]  <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_key_r <= res_nxt;
      out_st_r  <= st_nxt;
      out_ec_r  <= count_to_field(count_nxt);
    end
  end

  assign out_result_key  = out_key_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_ec_r;

endmodule

>>> rtl/unsorted_key_table_dictionary_unit.sv
// Unsorted key table: a multiset of up to CAPACITY signed 32-bit keys with
// insert, delete, search, min, max, predecessor and successor requests. Every
// request walks all CAPACITY slots through the single read port of the key
// memory, one slot per cycle. A request is accepted, its slots are read in
// turn, the last compare is made, and then the table is updated and the
// registered result is loaded, when the output is free to take it. The next
// request is taken in the cycle after the result is loaded, even while that
// result still waits at the output. The table is empty after reset;
// duplicate keys are kept.
module unsorted_key_table_dictionary_unit
  import ukt_pkg::*;
(
  input logic           clk,
  input logic           rst_n,
  ukt_in_if.sink        in_ch,
  ukt_out_if.source     out_ch
);

  ukt_cmd_t cmd;
  ukt_sts_t sts;

  // request sequencing
  ukt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // key store, scan compare and result register
  ukt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_key          (in_ch.key),
    .out_result_key  (out_ch.result_key),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

>>> rtl/ukt_checker.sv
module ukt_checker
  import ukt_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] out_result_key,
  input logic [ST_W-1:0]         out_status,
  input logic [EC_W-1:0]         out_entry_count
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during a scan");

  // failed requests return a zero key
  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_key == '0)
    else $error("non-zero key with failing status");

  // count never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_entry_count} <= (EC_W + 1)'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind unsorted_key_table_dictionary_unit ukt_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_key  (out_ch.result_key),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count)
);
